// File: rtl/byte_stuffing_deframer_assert.svh
// -----------------------------------------------------------------------------
// Byte-stuffing deframer assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while the active-low reset is asserted.
// -----------------------------------------------------------------------------
`ifndef BYTE_STUFFING_DEFRAMER_ASSERT_SVH
`define BYTE_STUFFING_DEFRAMER_ASSERT_SVH

// Same-cycle implication.
`define BSD_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/bsd_pkg.sv
// -----------------------------------------------------------------------------
// Byte-stuffing deframer package
// Result kinds, framing constants and the types passed between the
// front end, the result queue and the output stage.
// -----------------------------------------------------------------------------
package bsd_pkg;

  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE  = 8'h7D;
  localparam logic [7:0] ESC_XOR   = 8'h20;
  localparam logic [7:0] MAX_LEN_RESET = 8'd255;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_DONE = 2'd1,
    KIND_SYNC = 2'd2,
    KIND_FULL = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data_byte;
    logic [7:0] frame_length;
  } result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// File: rtl/bsd_if.sv
// -----------------------------------------------------------------------------
// Byte-stuffing deframer channels
// Valid/ready channels for received bytes, results and the configuration
// write.
// -----------------------------------------------------------------------------
interface bsd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface bsd_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic [7:0] frame_length;

  modport source (output valid, output kind, output data_byte, output frame_length,
                  input ready);
  modport sink   (input valid, input kind, input data_byte, input frame_length,
                  output ready);
endinterface

interface bsd_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/byte_stuffing_deframer.sv
// -----------------------------------------------------------------------------
// Byte-stuffing deframer
// Removes flag framing and escape stuffing from a received byte stream.
// -----------------------------------------------------------------------------
// Usage:
//   rx_i   carries one raw link byte per transfer. Bytes with flag 0x7E open
//          and close frames; 0x7D escapes the next byte (XOR 0x20).
//   res_o  carries zero or one result per byte: data byte, frame complete
//          with length, out of sync while hunting, or last byte of a frame
//          that reached max_frame_len (with its length).
//   cfg_i  writes max_frame_len; write only while no results are in flight.
//   Throughput is one byte per cycle while the result queue is not full.
//   The transfer of a byte writes its result into the result queue; the
//   output register that drives res_o loads it once free or being emptied.
//   Reset clears framing state to hunting, sets max_frame_len to 255 and
//   empties the queue and output register.
//   When the receiver stalls, the output register holds its result and
//   the queue absorbs up to QueueDepth more; rx_i.ready then drops until
//   the receiver takes a result.
// -----------------------------------------------------------------------------
module byte_stuffing_deframer #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bsd_rx_if.sink     rx_i,
  bsd_cfg_if.sink    cfg_i,
  bsd_res_if.source  res_o
);
  import bsd_pkg::*;

  logic      push;
  logic      pop;
  result_t   push_data;
  result_t   head;
  q_status_t q_status;

  bsd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_i        (rx_i),
    .cfg_i       (cfg_i),
    .q_status_i  (q_status),
    .push_o      (push),
    .push_data_o (push_data)
  );

  bsd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .status_o    (q_status)
  );

  bsd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .q_status_i (q_status),
    .pop_o      (pop),
    .res_o      (res_o)
  );

endmodule

// File: rtl/bsd_front.sv
// -----------------------------------------------------------------------------
// Byte-stuffing deframer front end
// Accepts received bytes, tracks framing and escape state, and pushes one
// classified result per byte that produces one.
// -----------------------------------------------------------------------------
`include "byte_stuffing_deframer_assert.svh"

module bsd_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  bsd_rx_if.sink             rx_i,
  bsd_cfg_if.sink            cfg_i,
  input  bsd_pkg::q_status_t q_status_i,
  output logic               push_o,
  output bsd_pkg::result_t   push_data_o
);
  import bsd_pkg::*;

  logic       in_frame_q, in_frame_d;
  logic       esc_q, esc_d;
  logic [7:0] cnt_q, cnt_d;
  logic [7:0] max_len_q;

  logic       rx_fire;
  logic       emit;
  logic [7:0] limit;
  logic [7:0] cnt_inc;
  logic [7:0] data_byte;
  result_t    res;

  assign rx_i.ready  = ~q_status_i.full;
  assign cfg_i.ready = 1'b1;
  assign rx_fire     = rx_i.valid & rx_i.ready;

  // A maximum of zero behaves like one.
  assign limit     = (max_len_q == 8'd0) ? 8'd1 : max_len_q;
  assign cnt_inc   = cnt_q + 8'd1;
  assign data_byte = esc_q ? (rx_i.rx_byte ^ ESC_XOR) : rx_i.rx_byte;

  always_comb begin
    in_frame_d = in_frame_q;
    esc_d      = esc_q;
    cnt_d      = cnt_q;
    emit       = 1'b0;
    res        = '{kind: KIND_DATA, data_byte: 8'd0, frame_length: 8'd0};

    if (!in_frame_q) begin
      if (rx_i.rx_byte == FLAG_BYTE) begin
        in_frame_d = 1'b1;
        esc_d      = 1'b0;
        cnt_d      = 8'd0;
      end else begin
        emit     = 1'b1;
        res.kind = KIND_SYNC;
      end
    end else if (rx_i.rx_byte == FLAG_BYTE) begin
      // A flag wins over a pending escape; an empty frame stays open.
      esc_d = 1'b0;
      if (cnt_q != 8'd0) begin
        emit             = 1'b1;
        res.kind         = KIND_DONE;
        res.frame_length = cnt_q;
        in_frame_d       = 1'b0;
        cnt_d            = 8'd0;
      end
    end else if (esc_q || (rx_i.rx_byte != ESC_BYTE)) begin
      esc_d         = 1'b0;
      emit          = 1'b1;
      res.data_byte = data_byte;
      if (cnt_inc >= limit) begin
        res.kind         = KIND_FULL;
        res.frame_length = cnt_inc;
        in_frame_d       = 1'b0;
        cnt_d            = 8'd0;
      end else begin
        cnt_d = cnt_inc;
      end
    end else begin
      esc_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      esc_q      <= 1'b0;
      cnt_q      <= 8'd0;
      max_len_q  <= MAX_LEN_RESET;
    end else begin
      if (rx_fire) begin
        in_frame_q <= in_frame_d;
        esc_q      <= esc_d;
        cnt_q      <= cnt_d;
      end
      if (cfg_i.valid && cfg_i.ready) begin
        max_len_q <= cfg_i.data;
      end
    end
  end

  assign push_o      = rx_fire & emit;
  assign push_data_o = res;

  `BSD_ASSERT_IMPLIES(a_count_in_frame, clk_i, rst_ni, cnt_q != 8'd0, in_frame_q,
                      "byte count nonzero while hunting")
  `BSD_ASSERT_IMPLIES(a_esc_in_frame, clk_i, rst_ni, esc_q, in_frame_q,
                      "escape pending while hunting")

endmodule

// File: rtl/bsd_queue.sv
// -----------------------------------------------------------------------------
// Byte-stuffing deframer result queue
// Small FIFO between the front end and the output stage so that each side
// can stall on its own.
// -----------------------------------------------------------------------------
`include "byte_stuffing_deframer_assert.svh"

module bsd_queue #(
  parameter int unsigned Depth = 2  // at least 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  bsd_pkg::result_t   push_data_i,
  input  logic               pop_i,
  output bsd_pkg::result_t   head_o,
  output bsd_pkg::q_status_t status_o
);
  import bsd_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  result_t             mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     cnt_q, cnt_d;

  always_comb begin
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign head_o         = mem_q[rd_ptr_q];
  assign status_o.full  = (cnt_q == CntW'(Depth));
  assign status_o.empty = (cnt_q == '0);

  `BSD_ASSERT_IMPLIES(a_no_push_full, clk_i, rst_ni, push_i, !status_o.full,
                      "push into full result queue")
  `BSD_ASSERT_IMPLIES(a_no_pop_empty, clk_i, rst_ni, pop_i, !status_o.empty,
                      "pop from empty result queue")
  `BSD_ASSERT_NEXT(a_push_fills, clk_i, rst_ni, push_i && !pop_i, !status_o.empty,
                   "result queue empty after push")

endmodule

// File: rtl/bsd_back.sv
// -----------------------------------------------------------------------------
// Byte-stuffing deframer output stage
// Drains the result queue into an output register that holds a result
// until the receiver takes it.
// -----------------------------------------------------------------------------
module bsd_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bsd_pkg::result_t   head_i,
  input  bsd_pkg::q_status_t q_status_i,
  output logic               pop_o,
  bsd_res_if.source          res_o
);
  import bsd_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  // Advance when the output register is free or being emptied this cycle.
  assign pop_o   = ~q_status_i.empty & (~valid_q | res_o.ready);
  assign valid_d = pop_o | (valid_q & ~res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= head_i;
    end
  end

  assign res_o.valid        = valid_q;
  assign res_o.kind         = res_q.kind;
  assign res_o.data_byte    = res_q.data_byte;
  assign res_o.frame_length = res_q.frame_length;

endmodule

// File: tb/tb_byte_stuffing_deframer.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Byte-stuffing deframer testbench
// Feeds raw link bytes (noise, well-formed stuffed frames and broken ones)
// through the deframer under several frame-length limits and idle patterns,
// and checks every result against a cycle-free model of the unstuffing logic.
// -----------------------------------------------------------------------------
module tb_byte_stuffing_deframer;
  import bsd_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int SettleCycles = 4;
  localparam int ReportMax = 10;

  logic clk_i;
  logic rst_ni;

  bsd_rx_if  rx_ch ();
  bsd_cfg_if cfg_ch ();
  bsd_res_if res_ch ();

  byte_stuffing_deframer uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .rx_i  (rx_ch),
    .cfg_i (cfg_ch),
    .res_o (res_ch)
  );

  // Link bytes waiting to be driven, and results the deframer still owes.
  logic [7:0] link_bytes[$];
  result_t    deframed_results[$];

  // Model state.
  logic       mdl_in_frame;
  logic       mdl_esc_pending;
  logic [7:0] mdl_count;
  logic [7:0] mdl_max_len;

  int  tx_idle_pct;
  int  rx_stall_pct;
  logic rx_taken;
  int  mismatches;
  int  cycle_count;
  int  pushed;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Deframe one link byte and queue the result it causes, if any.
  task automatic unstuff_and_frame(input logic [7:0] b);
    logic [7:0] val;
    logic [7:0] limit;
    result_t r;
    val = b;
    r = '0;
    if (!mdl_in_frame) begin
      if (b == FLAG_BYTE) begin
        mdl_in_frame = 1'b1;
        mdl_esc_pending = 1'b0;
        mdl_count = 8'd0;
      end else begin
        r.kind = KIND_SYNC;
        deframed_results.push_back(r);
      end
    end else if (b == FLAG_BYTE) begin
      mdl_esc_pending = 1'b0;
      if (mdl_count != 8'd0) begin
        r.kind = KIND_DONE;
        r.frame_length = mdl_count;
        deframed_results.push_back(r);
        mdl_in_frame = 1'b0;
        mdl_count = 8'd0;
      end
    end else if (!mdl_esc_pending && b == ESC_BYTE) begin
      mdl_esc_pending = 1'b1;
    end else begin
      if (mdl_esc_pending) begin
        val = b ^ ESC_XOR;
        mdl_esc_pending = 1'b0;
      end
      mdl_count = mdl_count + 8'd1;
      limit = (mdl_max_len == 8'd0) ? 8'd1 : mdl_max_len;
      r.data_byte = val;
      if (mdl_count >= limit) begin
        r.kind = KIND_FULL;
        r.frame_length = mdl_count;
        mdl_in_frame = 1'b0;
        mdl_esc_pending = 1'b0;
        mdl_count = 8'd0;
      end else begin
        r.kind = KIND_DATA;
      end
      deframed_results.push_back(r);
    end
  endtask

  // Check results first, then predict for the byte transferred at this edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_ch.valid && res_ch.ready) begin
        if (deframed_results.size() == 0) begin
          mismatches++;
          if (mismatches <= ReportMax)
            $display("unexpected result: kind %0d data %02h len %0d",
                     res_ch.kind, res_ch.data_byte, res_ch.frame_length);
        end else begin
          result_t exp_r;
          exp_r = deframed_results.pop_front();
          if (res_ch.kind !== exp_r.kind || res_ch.data_byte !== exp_r.data_byte ||
              res_ch.frame_length !== exp_r.frame_length) begin
            mismatches++;
            if (mismatches <= ReportMax)
              $display("mismatch: expected kind %0d data %02h len %0d,",
                       exp_r.kind, exp_r.data_byte, exp_r.frame_length,
                       " got kind %0d data %02h len %0d",
                       res_ch.kind, res_ch.data_byte, res_ch.frame_length);
          end
        end
      end
      if (rx_ch.valid && rx_ch.ready)
        unstuff_and_frame(rx_ch.rx_byte);
    end
    rx_taken <= rst_ni && rx_ch.valid && rx_ch.ready;
  end

  // Driver: present the next byte once the current one is transferred.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!rx_ch.valid || rx_taken) begin
        if (link_bytes.size() > 0 && $urandom_range(99, 0) >= tx_idle_pct) begin
          rx_ch.valid   <= 1'b1;
          rx_ch.rx_byte <= link_bytes.pop_front();
        end else begin
          rx_ch.valid   <= 1'b0;
          rx_ch.rx_byte <= 8'($urandom);
        end
      end
      res_ch.ready <= ($urandom_range(99, 0) >= rx_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_byte_stuffing_deframer: done, errors");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] b);
    link_bytes.push_back(b);
    pushed++;
  endtask

  // Stuff one payload byte; sometimes escape a byte that needs no escape.
  task automatic push_payload(input logic [7:0] b);
    if (b == FLAG_BYTE || b == ESC_BYTE ||
        ((b ^ ESC_XOR) != FLAG_BYTE && $urandom_range(15, 0) == 0)) begin
      push_byte(ESC_BYTE);
      push_byte(b ^ ESC_XOR);
    end else begin
      push_byte(b);
    end
  endtask

  task automatic push_traffic(input int n_bytes);
    int sel;
    int len;
    pushed = 0;
    while (pushed < n_bytes) begin
      sel = $urandom_range(15, 0);
      len = ($urandom_range(7, 0) == 0) ? $urandom_range(40, 0) : $urandom_range(10, 1);
      case (sel)
        0: begin
          repeat ($urandom_range(3, 1)) push_byte(8'($urandom));
        end
        1: begin
          // escape then flag: the flag wins and ends the frame if it holds bytes
          push_byte(FLAG_BYTE);
          repeat ($urandom_range(3, 0)) push_payload(8'($urandom));
          push_byte(ESC_BYTE);
          push_byte(FLAG_BYTE);
        end
        2: begin
          push_byte(FLAG_BYTE);
        end
        3: begin
          push_byte(FLAG_BYTE);
          push_byte(ESC_BYTE);
          push_byte(ESC_BYTE);
          repeat (len) push_payload(8'($urandom));
          push_byte(FLAG_BYTE);
        end
        default: begin
          push_byte(FLAG_BYTE);
          repeat (len) push_payload(8'($urandom));
          push_byte(FLAG_BYTE);
        end
      endcase
    end
  endtask

  // Hold off until the sender is empty and every result has arrived.
  task automatic drain;
    while (link_bytes.size() > 0 || rx_ch.valid || deframed_results.size() > 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_max_len(input logic [7:0] v);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    do @(posedge clk_i); while (!cfg_ch.ready);
    mdl_max_len = v;
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
    cfg_ch.data  <= 8'h00;
  endtask

  task automatic run_phase(input logic [7:0] max_len, input int tx_pct, input int rx_pct,
                           input int n_bytes);
    write_max_len(max_len);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    push_traffic(n_bytes);
    drain();
  endtask

  initial begin
    rx_ch.valid    = 1'b0;
    rx_ch.rx_byte  = 8'h00;
    res_ch.ready   = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.data    = 8'h00;
    rx_taken       = 1'b0;
    mismatches     = 0;
    cycle_count    = 0;
    tx_idle_pct    = 0;
    rx_stall_pct   = 0;
    mdl_in_frame    = 1'b0;
    mdl_esc_pending = 1'b0;
    mdl_count       = 8'd0;
    mdl_max_len     = MAX_LEN_RESET;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Noise while hunting, empty frames, escapes, escaped flag, escape pairs.
    begin
      logic [7:0] directed[20];
      directed = '{8'h00, 8'hFF, ESC_BYTE, FLAG_BYTE, FLAG_BYTE, ESC_BYTE, FLAG_BYTE,
                   8'h00, 8'hFF, ESC_BYTE, 8'h5E, ESC_BYTE, 8'h5D, ESC_BYTE, ESC_BYTE,
                   FLAG_BYTE, FLAG_BYTE, 8'h41, ESC_BYTE, FLAG_BYTE};
      foreach (directed[i]) push_byte(directed[i]);
    end
    // Fill a frame to the reset limit of 255 bytes.
    push_byte(FLAG_BYTE);
    repeat (255) push_byte(8'($urandom_range(8'h7C, 0)));
    drain();

    run_phase(8'd1, 78, 0, 100);
    run_phase(8'd255, 0, 78, 130);
    run_phase(8'd5, 22, 22, 130);
    run_phase(8'($urandom_range(254, 2)), 0, 0, 100);

    if (mismatches == 0 && deframed_results.size() == 0)
      $display("tb_byte_stuffing_deframer: done, clean");
    else
      $display("tb_byte_stuffing_deframer: done, errors");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/bsd_pkg.sv
rtl/bsd_if.sv
rtl/bsd_front.sv
rtl/bsd_queue.sv
rtl/bsd_back.sv
rtl/byte_stuffing_deframer.sv
tb/tb_byte_stuffing_deframer.sv
